### rtl/lsgm_pkg.sv
package lsgm_pkg;

  localparam int GRID_SIDE       = 128;
  localparam int SINE_TABLE_BITS = 10;

  localparam int SINE_Q    = 1 << SINE_TABLE_BITS;
  localparam int PHASE_W   = SINE_TABLE_BITS + 2;
  localparam int ROM_AW    = SINE_TABLE_BITS + 1;
  localparam int TRIG_W    = 15;
  localparam int GIDX_W    = $clog2(GRID_SIDE);
  localparam int MAP_AW    = 2 * GIDX_W;
  localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int CNT_W     = ($clog2(GRID_SIDE + 1) > 8) ? $clog2(GRID_SIDE + 1) : 8;
  localparam int G_W       = 34;
  localparam int REM_W     = 19;
  localparam int QUO_W     = 8;
  localparam int ONE_Q14   = 16384;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [1:0] {
    MODE_BEAM  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_POSE_X     = 3'd0,
    REG_POSE_Y     = 3'd1,
    REG_POSE_YAW   = 3'd2,
    REG_START      = 3'd3,
    REG_STEP       = 3'd4,
    REG_CELL_SIZE  = 3'd5,
    REG_GRID_COLS  = 3'd6,
    REG_GRID_ROWS  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    mode_t      mode;
    logic       rvalid;
    logic [6:0] rx;
    logic [6:0] ry;
  } item_t;

  typedef logic [TRIG_W-1:0] sine_rom_t [SINE_Q+1];

  // Quarter-wave sine in Q14, Taylor series in Q30, built at elaboration.
  function automatic sine_rom_t build_sine();
    sine_rom_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] s;
    logic signed [63:0] q;
    for (int k = 0; k <= SINE_Q; k++) begin
      x  = (64'(k) * PI_Q30) >> (SINE_TABLE_BITS + 1);
      x2 = (x * x) >> 30;
      t  = x;
      s  = 64'sd0;
      for (int n = 0; n < 8; n++) begin
        if ((n & 1) != 0) s = s - $signed(t);
        else s = s + $signed(t);
        t = ((t * x2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
      end
      if (s < 0) s = 64'sd0;
      q = (s + 64'sd32768) >>> 16;
      if (q > 64'sd16384) q = 64'sd16384;
      tab[k] = TRIG_W'(q);
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

### rtl/laser_scan_grid_marker_unit.sv
// Throughput: one beam or read beat per cycle while the output is not stalled and no
// clear is pending or sweeping, limited by the single map write/read stage.
// A clear beat blocks input until it reaches the map stage and the sweep that follows
// it, one cell per cycle over all GRID_SIDE*GRID_SIDE (16384) cells, is done.
// Reset is synchronous; after reset the same sweep runs before s_tready rises.
// Configuration writes are taken at any time, including during a sweep.
module laser_scan_grid_marker_unit import lsgm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // beam_index[11:0], range_mm[27:12], read_x[34:28],
                                // read_y[41:35], zero[47:42]
  input  logic [2:0]  s_tuser,  // mode[1:0], range_valid[2]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // cell_x[6:0], cell_y[13:7], cell_state[14], zero[15]
  output logic [0:0]  m_tuser   // hit_in_map[0]
);

  // ---------------- configuration registers ----------------
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic [15:0]        pose_yaw;
  logic [15:0]        start_angle;
  logic [15:0]        angle_step;
  logic [9:0]         cell_size;
  logic [7:0]         grid_cols;
  logic [7:0]         grid_rows;

  cfg_reg_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x      <= '0;
      pose_y      <= '0;
      pose_yaw    <= '0;
      start_angle <= '0;
      angle_step  <= 16'd16;
      cell_size   <= 10'd100;
      grid_cols   <= 8'd100;
      grid_rows   <= 8'd100;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POSE_X:    pose_x      <= pwdata[15:0];
        REG_POSE_Y:    pose_y      <= pwdata[15:0];
        REG_POSE_YAW:  pose_yaw    <= pwdata[15:0];
        REG_START:     start_angle <= pwdata[15:0];
        REG_STEP:      angle_step  <= pwdata[15:0];
        REG_CELL_SIZE: cell_size   <= pwdata[9:0];
        REG_GRID_COLS: grid_cols   <= pwdata[7:0];
        REG_GRID_ROWS: grid_rows   <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_POSE_X:    prdata = {16'd0, pose_x};
      REG_POSE_Y:    prdata = {16'd0, pose_y};
      REG_POSE_YAW:  prdata = {16'd0, pose_yaw};
      REG_START:     prdata = {16'd0, start_angle};
      REG_STEP:      prdata = {16'd0, angle_step};
      REG_CELL_SIZE: prdata = {22'd0, cell_size};
      REG_GRID_COLS: prdata = {24'd0, grid_cols};
      REG_GRID_ROWS: prdata = {24'd0, grid_rows};
    endcase
  end

  // Derived config: zero cell means 1 mm, used area clamps to the stored grid.
  logic [9:0] cell_eff;
  logic [7:0] lim [2];   // lane 0 = x (columns), lane 1 = y (rows)

  assign cell_eff = (cell_size == 10'd0) ? 10'd1 : cell_size;
  assign lim[0]   = (CNT_W'(grid_cols) > CNT_W'(GRID_SIDE)) ? 8'(GRID_SIDE) : grid_cols;
  assign lim[1]   = (CNT_W'(grid_rows) > CNT_W'(GRID_SIDE)) ? 8'(GRID_SIDE) : grid_rows;

  // Map-centering offset in Q14 mm, registered in two steps; the user keeps config quiet
  // while the block is idle (unenforced), so these settle before any beat uses them.
  logic [17:0]          half_ext [2];
  logic signed [G_W-1:0] offset  [2];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      half_ext[l] <= 18'(lim[l]) * 18'(cell_eff);
    end
    offset[0] <= G_W'($signed({pose_x, 14'd0})) + G_W'($signed({1'b0, half_ext[0], 13'd0}));
    offset[1] <= G_W'($signed({pose_y, 14'd0})) + G_W'($signed({1'b0, half_ext[1], 13'd0}));
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic vo;
  logic clearing;
  logic clear_pending;
  logic [MAP_AW-1:0] clear_ptr;

  assign adv      = !vo || m_tready;
  assign s_tready = adv && !clearing && !clear_pending;

  // stage 1: beam angle
  logic        v1;
  item_t       it1;
  logic [15:0] rng1;
  logic [15:0] ang1;
  item_t       in_item;
  logic [15:0] idx_step;

  assign in_item.mode   = mode_t'(s_tuser[1:0]);
  assign in_item.rvalid = s_tuser[2];
  assign in_item.rx     = s_tdata[34:28];
  assign in_item.ry     = s_tdata[41:35];
  assign idx_step       = 16'(s_tdata[11:0] * angle_step);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_tvalid && s_tready;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1  <= in_item;
      rng1 <= s_tdata[27:12];
      ang1 <= start_angle + idx_step + pose_yaw;
    end
  end

  // stage 2: quarter-wave table read, lane 0 cosine, lane 1 sine
  logic              v2;
  item_t             it2;
  logic [15:0]       rng2;
  logic [TRIG_W-1:0] mag2 [2];
  logic              neg2 [2];
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] ph   [2];
  logic [ROM_AW-1:0]  raddr [2];

  assign phase = ang1[15 -: PHASE_W];
  assign ph[0] = phase + PHASE_W'(SINE_Q);
  assign ph[1] = phase;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      raddr[l] = ph[l][SINE_TABLE_BITS] ?
                 ROM_AW'(SINE_Q) - ROM_AW'(ph[l][SINE_TABLE_BITS-1:0]) :
                 ROM_AW'(ph[l][SINE_TABLE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it2  <= it1;
      rng2 <= rng1;
      for (int l = 0; l < 2; l++) begin
        mag2[l] <= SINE_ROM[raddr[l]];
        neg2[l] <= ph[l][PHASE_W-1];
      end
    end
  end

  // stage 3: scale by range
  logic                  v3;
  item_t                 it3;
  logic signed [G_W-1:0] prod3 [2];
  logic signed [15:0]    trig  [2];
  logic signed [32:0]    prod  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trig[l] = neg2[l] ? -$signed({1'b0, mag2[l]}) : $signed({1'b0, mag2[l]});
      prod[l] = $signed({1'b0, rng2}) * trig[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it3 <= it2;
      for (int l = 0; l < 2; l++) prod3[l] <= G_W'(prod[l]);
    end
  end

  // stage 4: translate into map frame
  logic                  v4;
  item_t                 it4;
  logic signed [G_W-1:0] g4 [2];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it4 <= it3;
      for (int l = 0; l < 2; l++) g4[l] <= prod3[l] + offset[l];
    end
  end

  // stages 5..8: restoring division by the cell size, two quotient bits a stage.
  // Q14 fraction bits drop first; a quotient of 256 or more is outside any map.
  logic             vd   [4];
  item_t            itd  [4];
  logic [REM_W-1:0] rem  [4][2];
  logic [QUO_W-1:0] quo  [4][2];
  logic             bad  [4][2];
  logic [REM_W-1:0] rem_n [4][2];
  logic [QUO_W-1:0] quo_n [4][2];
  logic             bad_n [4][2];
  logic [REM_W-1:0] dvs;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int l = 0; l < 2; l++) begin
        if (j == 0) begin
          rem_n[j][l] = g4[l][32:14];
          quo_n[j][l] = '0;
          bad_n[j][l] = g4[l][G_W-1] || (g4[l][32:14] >= {1'b0, cell_eff, 8'd0});
        end else begin
          rem_n[j][l] = rem[j-1][l];
          quo_n[j][l] = quo[j-1][l];
          bad_n[j][l] = bad[j-1][l];
        end
        for (int b = 0; b < 2; b++) begin
          dvs = REM_W'(cell_eff) << (7 - 2 * j - b);
          if (rem_n[j][l] >= dvs) begin
            rem_n[j][l] = rem_n[j][l] - dvs;
            quo_n[j][l][7 - 2 * j - b] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 4; j++) vd[j] <= 1'b0;
    end else if (adv) begin
      vd[0] <= v4;
      for (int j = 1; j < 4; j++) vd[j] <= vd[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itd[0] <= it4;
      for (int j = 1; j < 4; j++) itd[j] <= itd[j-1];
      for (int j = 0; j < 4; j++) begin
        for (int l = 0; l < 2; l++) begin
          rem[j][l] <= rem_n[j][l];
          quo[j][l] <= quo_n[j][l];
          bad[j][l] <= bad_n[j][l];
        end
      end
    end
  end

  // ---------------- map stage ----------------
  item_t             itm;
  logic              vm;
  logic              hit;
  logic              is_read;
  logic              in_store;
  logic [GIDX_W-1:0] rdx;
  logic [GIDX_W-1:0] rdy;
  logic [MAP_AW-1:0] map_waddr;
  logic [MAP_AW-1:0] map_raddr;
  logic              map [MAP_DEPTH];
  logic              map_rd;

  assign itm = itd[3];
  assign vm  = vd[3];
  assign hit = vm && (itm.mode == MODE_BEAM) && itm.rvalid &&
               !bad[3][0] && !bad[3][1] &&
               (quo[3][0] < lim[0]) && (quo[3][1] < lim[1]);
  assign is_read   = vm && (itm.mode == MODE_READ);
  assign in_store  = (CNT_W'(itm.rx) < CNT_W'(GRID_SIDE)) &&
                     (CNT_W'(itm.ry) < CNT_W'(GRID_SIDE));
  assign rdx       = GIDX_W'(itm.rx);
  assign rdy       = GIDX_W'(itm.ry);
  assign map_waddr = {GIDX_W'(quo[3][1]), GIDX_W'(quo[3][0])};
  assign map_raddr = {rdy, rdx};

  // Sweep owns the write port; no beam can be in flight behind a clear.
  always_ff @(posedge clk) begin
    if (clearing) map[clear_ptr] <= 1'b0;
    else if (adv && hit) map[map_waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (adv) map_rd <= map[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clear_pending <= 1'b0;
      clear_ptr     <= '0;
    end else begin
      if (s_tvalid && s_tready && (in_item.mode == MODE_CLEAR)) clear_pending <= 1'b1;
      if (clearing) begin
        if (clear_ptr == MAP_AW'(MAP_DEPTH - 1)) begin
          clearing      <= 1'b0;
          clear_pending <= 1'b0;
          clear_ptr     <= '0;
        end else begin
          clear_ptr <= clear_ptr + 1'b1;
        end
      end else if (adv && vm && (itm.mode == MODE_CLEAR)) begin
        clearing <= 1'b1;
      end
    end
  end

  // ---------------- output register ----------------
  logic [6:0] o_cx;
  logic [6:0] o_cy;
  logic       o_hit;
  logic       o_rsel;

  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (adv) vo <= vm;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_hit  <= hit;
      o_rsel <= is_read && in_store;
      if (hit) begin
        o_cx <= quo[3][0][6:0];
        o_cy <= quo[3][1][6:0];
      end else if (is_read) begin
        o_cx <= itm.rx;
        o_cy <= itm.ry;
      end else begin
        o_cx <= '0;
        o_cy <= '0;
      end
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = {1'b0, o_rsel & map_rd, o_cy, o_cx};
  assign m_tuser  = o_hit;

  // ---------------- assertions ----------------
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted during map sweep");

  a_hit_no_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tdata[14])
    else $error("beam result carries a cell state");

  a_sweep_ends_at_zero: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> (clear_ptr == '0) && !clear_pending)
    else $error("sweep ended with pointer off zero");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[1:0] == MODE_CLEAR) |=> !s_tready)
    else $error("input taken right after a clear beat");

endmodule
